// ----- hdl/eca_pkg.sv -----
// Shared types and constants for the elementary cellular automaton ring.
// Used by eca_cell_mem, eca_seq and the top level; depends on nothing.
`default_nettype none

package eca_pkg;

  localparam int CELLS_DEF     = 256;
  localparam int GEN_WIDTH_DEF = 32;

  localparam int CMD_W    = 2;
  localparam int IDX_W    = 8;
  localparam int RULE_W   = 8;
  localparam int COUNT_W  = 9;
  localparam int GEN_OUT_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RULE       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] cell_index;
    logic             cell_value;
  } eca_in_t;

  typedef struct packed {
    logic                 read_value;
    logic [GEN_OUT_W-1:0] generation;
  } eca_out_t;

  typedef struct packed {
    logic wr_en;
    logic wr_data;
    logic rd_en;
  } eca_mem_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/eca_cell_mem.sv -----
// Cell store: one-bit wide synchronous memory, one write and one read port.
// Read data is registered. Uses eca_pkg for the control struct.
`default_nettype none

module eca_cell_mem #(
  parameter int DEPTH = eca_pkg::CELLS_DEF,
  parameter int AW    = $clog2(eca_pkg::CELLS_DEF)
) (
  input  wire                      clk,
  input  wire eca_pkg::eca_mem_ctl_t ctl,
  input  wire  [AW-1:0]            waddr,
  input  wire  [AW-1:0]            raddr,
  output logic                     rd_data_r
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/eca_seq.sv -----
// Command sequencer: clears the cell store after reset, runs write/read requests
// and the generation sweep against eca_cell_mem. Depends on eca_pkg.
`default_nettype none

module eca_seq #(
  parameter int CELLS     = eca_pkg::CELLS_DEF,
  parameter int GEN_WIDTH = eca_pkg::GEN_WIDTH_DEF,
  parameter int AW        = $clog2(eca_pkg::CELLS_DEF),
  parameter int CW        = $clog2(eca_pkg::CELLS_DEF + 2)
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire eca_pkg::eca_in_t          in_data,
  input  wire  [eca_pkg::RULE_W-1:0]     rule,
  input  wire  [CW-1:0]                  n_eff,
  output logic                           res_valid,
  input  wire                            res_ready,
  output eca_pkg::eca_out_t              res_data,
  output eca_pkg::eca_mem_ctl_t          mem_ctl,
  output logic [AW-1:0]                  mem_waddr,
  output logic [AW-1:0]                  mem_raddr,
  input  wire                            mem_rd_data
);

  localparam int CMP_W = (CW > eca_pkg::IDX_W) ? CW : eca_pkg::IDX_W;
  localparam int GX_W  = (GEN_WIDTH > eca_pkg::GEN_OUT_W) ? GEN_WIDTH : eca_pkg::GEN_OUT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_SWEEP = 6'b001000,
    ST_LAST  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [CW-1:0]          iss_r, iss_nxt;
  logic [CW-1:0]          st_r, st_nxt;
  logic                   pend_r, pend_nxt;
  logic                   left_r, left_nxt;
  logic                   mid_r, mid_nxt;
  logic                   first_r, first_nxt;
  logic                   rv_r, rv_nxt;
  logic [GEN_WIDTH-1:0]   gen_r, gen_nxt;

  logic [CMP_W-1:0]       idx_ext;
  logic [CMP_W-1:0]       n_ext;
  logic                   in_rng;
  logic [CW-1:0]          iss_m1;
  logic [CW-1:0]          st_m2;
  logic [CW-1:0]          n_m1;
  logic [GX_W-1:0]        gen_ext;

  assign idx_ext = CMP_W'(in_data.cell_index);
  assign n_ext   = CMP_W'(n_eff);
  assign in_rng  = idx_ext < n_ext;
  assign iss_m1  = iss_r - CW'(1);
  assign st_m2   = st_r - CW'(2);
  assign n_m1    = n_eff - CW'(1);
  assign gen_ext = GX_W'(gen_r);

  assign in_stall            = (state_r != ST_IDLE);
  assign res_valid           = (state_r == ST_DONE);
  assign res_data.read_value = rv_r;
  assign res_data.generation = gen_ext[eca_pkg::GEN_OUT_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    iss_nxt         = iss_r;
    st_nxt          = st_r;
    pend_nxt        = 1'b0;
    left_nxt        = left_r;
    mid_nxt         = mid_r;
    first_nxt       = first_r;
    rv_nxt          = rv_r;
    gen_nxt         = gen_r;
    mem_ctl.wr_en   = 1'b0;
    mem_ctl.wr_data = 1'b0;
    mem_ctl.rd_en   = 1'b0;
    mem_waddr       = idx_ext[AW-1:0];
    mem_raddr       = idx_ext[AW-1:0];

    unique case (state_r)
      ST_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        mem_waddr     = clr_r;
        clr_nxt       = clr_r + AW'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          rv_nxt = 1'b0;
          unique case (in_data.command)
            eca_pkg::CMD_WRITE: begin
              mem_ctl.wr_en   = in_rng;
              mem_ctl.wr_data = in_data.cell_value;
              state_nxt       = ST_DONE;
            end
            eca_pkg::CMD_ADVANCE: begin
              if (n_eff == '0) begin
                gen_nxt   = gen_r + GEN_WIDTH'(1);
                state_nxt = ST_DONE;
              end else begin
                iss_nxt   = '0;
                state_nxt = ST_SWEEP;
              end
            end
            eca_pkg::CMD_READ: begin
              if (in_rng) begin
                mem_ctl.rd_en = 1'b1;
                state_nxt     = ST_READ;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        rv_nxt    = mem_rd_data;
        state_nxt = ST_DONE;
      end
      ST_SWEEP: begin
        // read order: last cell (left of cell 0), then cells 0 .. n-1
        if (iss_r <= n_eff) begin
          mem_ctl.rd_en = 1'b1;
          mem_raddr     = (iss_r == '0) ? n_m1[AW-1:0] : iss_m1[AW-1:0];
          iss_nxt       = iss_r + CW'(1);
          pend_nxt      = 1'b1;
          st_nxt        = iss_r;
        end
        // writes trail reads by two cells, so old values are read first
        if (pend_r) begin
          if (st_r == '0) begin
            left_nxt = mem_rd_data;
          end else if (st_r == CW'(1)) begin
            mid_nxt   = mem_rd_data;
            first_nxt = mem_rd_data;
          end else begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_data = rule[{left_r, mid_r, mem_rd_data}];
            mem_waddr       = st_m2[AW-1:0];
            left_nxt        = mid_r;
            mid_nxt         = mem_rd_data;
          end
          if (st_r == n_eff) begin
            state_nxt = ST_LAST;
          end
        end
      end
      ST_LAST: begin
        // last cell wraps to the saved old value of cell 0
        mem_ctl.wr_en   = 1'b1;
        mem_ctl.wr_data = rule[{left_r, mid_r, first_r}];
        mem_waddr       = n_m1[AW-1:0];
        gen_nxt         = gen_r + GEN_WIDTH'(1);
        state_nxt       = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      pend_r  <= 1'b0;
      gen_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
      gen_r   <= gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r   <= iss_nxt;
    st_r    <= st_nxt;
    left_r  <= left_nxt;
    mid_r   <= mid_nxt;
    first_r <= first_nxt;
    rv_r    <= rv_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/elementary_cellular_automaton_ring.sv -----
// Elementary cellular automaton on a ring of one-bit cells held in a synchronous
// memory. After reset the block clears the cell memory, one cell a cycle, and takes
// no request until every cell is cleared. A read of a cell in range waits in a read
// state for the registered read data of the cell memory. An advance sweeps the ring
// through the memory's read and write ports at one cell a cycle; it reads the last
// cell, then cells 0 to n-1 for n cells in use, and writes each new value two cells
// behind, so the whole ring updates at once. A result waits while the output
// register is full and stalled. Every request returns one result with the read
// value and the generation count. The user must write rule and cell_count through
// the cfg port only while no request is in flight; the block does not enforce it.
`default_nettype none

module elementary_cellular_automaton_ring #(
  parameter int CELLS     = eca_pkg::CELLS_DEF,
  parameter int GEN_WIDTH = eca_pkg::GEN_WIDTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire eca_pkg::eca_in_t                in_data,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output eca_pkg::eca_out_t                    out_data,
  input  wire                                  cfg_we,
  input  wire  [eca_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [eca_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 2);
  localparam int CNT_W = (CW > eca_pkg::COUNT_W) ? CW : eca_pkg::COUNT_W;

  logic [eca_pkg::RULE_W-1:0]  rule_r;
  logic [eca_pkg::COUNT_W-1:0] cell_count_r;
  logic [CNT_W-1:0]            cc_ext;
  logic [CW-1:0]               n_eff;

  logic                        res_valid;
  logic                        res_ready;
  eca_pkg::eca_out_t           res_data;
  logic                        out_valid_r, out_valid_nxt;
  eca_pkg::eca_out_t           out_data_r;

  eca_pkg::eca_mem_ctl_t       mem_ctl;
  logic [AW-1:0]               mem_waddr;
  logic [AW-1:0]               mem_raddr;
  logic                        mem_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r       <= '0;
      cell_count_r <= eca_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        eca_pkg::REG_RULE:       rule_r       <= cfg_wdata[eca_pkg::RULE_W-1:0];
        eca_pkg::REG_CELL_COUNT: cell_count_r <= cfg_wdata[eca_pkg::COUNT_W-1:0];
      endcase
    end
  end

  // counts above the ring size act as the full ring
  assign cc_ext = CNT_W'(cell_count_r);
  assign n_eff  = (cc_ext > CNT_W'(CELLS)) ? CW'(CELLS) : cc_ext[CW-1:0];

  eca_seq #(
    .CELLS     (CELLS),
    .GEN_WIDTH (GEN_WIDTH),
    .AW        (AW),
    .CW        (CW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .rule        (rule_r),
    .n_eff       (n_eff),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .mem_ctl     (mem_ctl),
    .mem_waddr   (mem_waddr),
    .mem_raddr   (mem_raddr),
    .mem_rd_data (mem_rd_data)
  );

  eca_cell_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .ctl       (mem_ctl),
    .waddr     (mem_waddr),
    .raddr     (mem_raddr),
    .rd_data_r (mem_rd_data)
  );

  // output register
  assign res_ready     = !out_valid_r || !out_stall;
  assign out_valid_nxt = (res_valid && res_ready) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("request taken while cell memory clears");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in flight");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> (out_valid && !res_valid))
    else $error("result lost or repeated at output register");
`endif

endmodule

`default_nettype wire
